>>> sv/ede_pkg.sv
// Shared types and constants for the edit distance engine.
package ede_pkg;

    localparam int CH_W = 8;

    typedef logic [CH_W-1:0] char_t;

    // op field codes
    localparam logic OP_SOURCE = 1'b0;
    localparam logic OP_TARGET = 1'b1;

    // control part of the wavefront token passed from cell to cell
    typedef struct packed {
        logic valid;
        logic upd;
        logic fin;
    } tok_ctl_t;

endpackage

>>> sv/ede_cell.sv
// One cell of the cost row: holds one source character and one row cost.
module ede_cell #(
    parameter int CW  = 7,
    parameter int IDX = 1
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  ede_pkg::char_t   wr_ch,
    input  ede_pkg::tok_ctl_t tin,
    input  ede_pkg::char_t   tch_in,
    input  logic [CW-1:0]    left_in,
    input  logic [CW-1:0]    diag_in,
    output ede_pkg::tok_ctl_t tout,
    output ede_pkg::char_t   tch_out,
    output logic [CW-1:0]    left_out,
    output logic [CW-1:0]    diag_out
);
    import ede_pkg::*;

    localparam logic [CW-1:0] RESET_COST = CW'(IDX);

    char_t          src_reg;
    logic           active_reg;
    logic           active_next;
    logic [CW-1:0]  cost_reg;
    logic [CW-1:0]  cost_next;
    tok_ctl_t       tout_reg;
    char_t          tch_reg;
    logic [CW-1:0]  left_reg;
    logic [CW-1:0]  left_next;
    logic [CW-1:0]  diag_reg;
    logic [CW-1:0]  min_ld;
    logic [CW-1:0]  min_all;
    logic [CW-1:0]  calc;

    assign min_ld  = (left_in < diag_in) ? left_in : diag_in;
    assign min_all = (cost_reg < min_ld) ? cost_reg : min_ld;
    assign calc    = (src_reg == tch_in) ? diag_in : min_all + CW'(1);

    always_comb
    begin
        left_next   = left_in;
        cost_next   = cost_reg;
        active_next = active_reg;
        if (wr_en)
        begin
            active_next = 1'b1;
        end
        if (tin.valid)
        begin
            if (active_reg)
            begin
                if (tin.upd)
                begin
                    left_next = calc;
                    cost_next = calc;
                end
                else
                begin
                    left_next = cost_reg;
                end
            end
            // final item: row entry returns to its initial value
            if (tin.fin)
            begin
                cost_next   = RESET_COST;
                active_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            cost_reg   <= RESET_COST;
            tout_reg   <= '0;
        end
        else
        begin
            active_reg <= active_next;
            cost_reg   <= cost_next;
            tout_reg   <= tin;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            src_reg <= wr_ch;
        end
        if (tin.valid)
        begin
            tch_reg  <= tch_in;
            left_reg <= left_next;
            diag_reg <= cost_reg;
        end
    end

    assign tout     = tout_reg;
    assign tch_out  = tch_reg;
    assign left_out = left_reg;
    assign diag_out = diag_reg;

endmodule

>>> sv/edit_distance_engine_unit.sv
// Top level of the edit distance engine: control and the row of cost cells.
//
//  channel | signals                            | direction
//  --------+------------------------------------+----------
//  in      | in_valid/in_ready, op ch no_char last | into block
//  out     | out_valid/out_ready, distance overflow | out of block
//
// Source and target items are taken back to back while in_ready is high;
// target characters enter the cell row back to back and ripple one cell per cycle (skewed wavefront).
// The result is registered once the last target item has passed the injection
// register and every cell of the row; no item is taken during that drain.
// A last target item also waits while an earlier result is still untaken.
// Reset is asynchronous, active low; the row resets to its index values.
module edit_distance_engine_unit #(
    parameter int MAX_LEN = 64
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           op,
    input  ede_pkg::char_t                 ch,
    input  logic                           no_char,
    input  logic                           last,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [$clog2(MAX_LEN+1)-1:0]   distance,
    output logic                           overflow
);
    import ede_pkg::*;

    localparam int CW = $clog2(MAX_LEN + 1);
    localparam logic [CW-1:0] LEN_LIMIT = CW'(MAX_LEN);

    logic           in_fire;
    logic           final_tgt;
    logic           src_acc;
    logic           src_wr;
    logic           tgt_acc;
    logic           tgt_upd;
    logic           tgt_end;
    logic           exceed_set;
    logic           row_exit;

    logic [CW-1:0]  src_len_reg;
    logic [CW-1:0]  src_len_next;
    logic [CW-1:0]  tcount_reg;
    logic [CW-1:0]  tcount_next;
    logic           exceeded_reg;
    logic           exceeded_next;
    logic           loading_reg;
    logic           loading_next;
    logic           drain_reg;
    logic           drain_next;
    logic           out_valid_reg;
    logic           out_valid_next;
    logic [CW-1:0]  distance_reg;
    logic           overflow_reg;

    tok_ctl_t       inj_ctl_reg;
    tok_ctl_t       inj_ctl_next;
    char_t          inj_ch_reg;
    logic [CW-1:0]  inj_left_reg;
    logic [CW-1:0]  inj_diag_reg;

    tok_ctl_t       tok_ctl  [MAX_LEN+1];
    char_t          tok_ch   [MAX_LEN+1];
    logic [CW-1:0]  tok_left [MAX_LEN+1];
    logic [CW-1:0]  tok_diag [MAX_LEN+1];

    assign final_tgt = (op == OP_TARGET) && last && loading_reg;
    assign in_ready  = !drain_reg && !(final_tgt && out_valid_reg);
    assign in_fire   = in_valid && in_ready;

    assign src_acc   = in_fire && (op == OP_SOURCE) && !loading_reg;
    assign src_wr    = src_acc && !no_char && (src_len_reg < LEN_LIMIT);
    assign tgt_acc   = in_fire && (op == OP_TARGET) && loading_reg;
    assign tgt_upd   = tgt_acc && !no_char && (tcount_reg < LEN_LIMIT);
    assign tgt_end   = tgt_acc && last;

    assign exceed_set = (src_acc && !no_char && (src_len_reg == LEN_LIMIT)) ||
                        (tgt_acc && !no_char && (tcount_reg == LEN_LIMIT));

    assign row_exit  = tok_ctl[MAX_LEN].valid && tok_ctl[MAX_LEN].fin;

    always_comb
    begin
        src_len_next   = src_len_reg;
        tcount_next    = tcount_reg;
        loading_next   = loading_reg;
        drain_next     = drain_reg;
        exceeded_next  = exceeded_reg | exceed_set;
        out_valid_next = out_valid_reg;
        inj_ctl_next.valid = tgt_upd || tgt_end;
        inj_ctl_next.upd   = tgt_upd;
        inj_ctl_next.fin   = tgt_end;

        if (src_wr)
        begin
            src_len_next = src_len_reg + CW'(1);
        end
        if (src_acc && last)
        begin
            loading_next = 1'b1;
        end
        if (tgt_upd)
        begin
            tcount_next = tcount_reg + CW'(1);
        end
        if (tgt_end)
        begin
            src_len_next = '0;
            tcount_next  = '0;
            loading_next = 1'b0;
            drain_next   = 1'b1;
        end
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (row_exit)
        begin
            drain_next     = 1'b0;
            exceeded_next  = 1'b0;
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_len_reg   <= '0;
            tcount_reg    <= '0;
            exceeded_reg  <= 1'b0;
            loading_reg   <= 1'b0;
            drain_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            inj_ctl_reg   <= '0;
        end
        else
        begin
            src_len_reg   <= src_len_next;
            tcount_reg    <= tcount_next;
            exceeded_reg  <= exceeded_next;
            loading_reg   <= loading_next;
            drain_reg     <= drain_next;
            out_valid_reg <= out_valid_next;
            inj_ctl_reg   <= inj_ctl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tgt_acc)
        begin
            inj_ch_reg   <= ch;
            inj_left_reg <= tgt_upd ? tcount_reg + CW'(1) : tcount_reg;
            inj_diag_reg <= tcount_reg;
        end
        if (row_exit)
        begin
            distance_reg <= tok_left[MAX_LEN];
            overflow_reg <= exceeded_reg;
        end
    end

    assign tok_ctl[0]  = inj_ctl_reg;
    assign tok_ch[0]   = inj_ch_reg;
    assign tok_left[0] = inj_left_reg;
    assign tok_diag[0] = inj_diag_reg;

    for (genvar k = 1; k <= MAX_LEN; k++)
    begin : g_cell
        logic cell_wr;

        assign cell_wr = src_wr && (src_len_reg == CW'(k - 1));

        ede_cell #(
            .CW  (CW),
            .IDX (k)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .wr_en    (cell_wr),
            .wr_ch    (ch),
            .tin      (tok_ctl[k-1]),
            .tch_in   (tok_ch[k-1]),
            .left_in  (tok_left[k-1]),
            .diag_in  (tok_diag[k-1]),
            .tout     (tok_ctl[k]),
            .tch_out  (tok_ch[k]),
            .left_out (tok_left[k]),
            .diag_out (tok_diag[k])
        );
    end

    assign out_valid = out_valid_reg;
    assign distance  = distance_reg;
    assign overflow  = overflow_reg;

endmodule

>>> sv/ede_checker.sv
// Port-level checks for the edit distance engine, bound to the top level.
module ede_checker #(
    parameter int MAX_LEN = 64
) (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           in_valid,
    input logic                           in_ready,
    input logic                           op,
    input logic                           last,
    input logic                           out_valid,
    input logic                           out_ready,
    input logic [$clog2(MAX_LEN+1)-1:0]   distance,
    input logic                           overflow
);
    import ede_pkg::*;

    localparam int CW = $clog2(MAX_LEN + 1);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(distance) && $stable(overflow))
        else $error("result changed while stalled");

    // a result only follows a last target item through the full row
    a_out_origin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |->
            $past(in_valid && in_ready && (op == OP_TARGET) && last, MAX_LEN + 2))
        else $error("result without matching last target item");

    // results are far apart: a taken result is not followed at once by another
    a_out_gap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready |=> !out_valid)
        else $error("back-to-back results");

    a_dist_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> distance <= CW'(MAX_LEN))
        else $error("distance beyond string limit");

endmodule

bind edit_distance_engine_unit ede_checker #(.MAX_LEN(MAX_LEN)) u_ede_checker (.*);
